FILE: rtl/core/mms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI menu selector package
// Shared types, codes and reset values for the MIDI menu selector.
// ----------------------------------------------------------------------------
package mms_pkg;

    // Number of menu entries by default, and the number of note registers.
    localparam int ENTRY_COUNT_DEFAULT = 3;
    localparam int NOTE_COUNT          = 3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_NEXT_CTRL   = 3'd0;
    localparam logic [2:0] CFG_PREV_CTRL   = 3'd1;
    localparam logic [2:0] CFG_SELECT_CTRL = 3'd2;
    localparam logic [2:0] CFG_NOTE_FIRST  = 3'd3;
    localparam logic [2:0] CFG_NOTE_SECOND = 3'd4;
    localparam logic [2:0] CFG_NOTE_THIRD  = 3'd5;

    // Configuration reset values.
    localparam logic [6:0] RST_NEXT_CTRL   = 7'd47;
    localparam logic [6:0] RST_PREV_CTRL   = 7'd46;
    localparam logic [6:0] RST_SELECT_CTRL = 7'd49;
    localparam logic [6:0] RST_NOTE_FIRST  = 7'd36;
    localparam logic [6:0] RST_NOTE_SECOND = 7'd38;
    localparam logic [6:0] RST_NOTE_THIRD  = 7'd40;

    // Upper nibbles of the status bytes that matter here.
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_CTRL     = 4'hB;
    localparam logic [3:0] KIND_PROGRAM  = 4'hC;
    localparam logic [3:0] KIND_PRESSURE = 4'hD;

    // Parser position within a message.
    localparam logic [1:0] IDX_NONE   = 2'd0;
    localparam logic [1:0] IDX_STATUS = 2'd1;
    localparam logic [1:0] IDX_DATA   = 2'd2;

    // Message lengths in bytes.
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    typedef enum logic [1:0] {
        ACT_MIDI    = 2'd0,
        ACT_FWD     = 2'd1,
        ACT_BACK    = 2'd2,
        ACT_CONFIRM = 2'd3
    } action_t;

    typedef struct packed {
        logic [6:0] next_ctrl;
        logic [6:0] prev_ctrl;
        logic [6:0] select_ctrl;
        logic [6:0] note_first;
        logic [6:0] note_second;
        logic [6:0] note_third;
    } cfg_t;

    typedef struct packed {
        logic [7:0] running_status;
        logic [1:0] byte_index;
        logic [1:0] message_length;
        logic [7:0] first_data;
        logic [1:0] selected_entry;
        logic       start_flag;
    } state_t;

    typedef struct packed {
        logic [1:0] selection;
        logic       start_requested;
        logic       redraw;
        logic       message_complete;
    } result_t;

endpackage

FILE: rtl/core/mms_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI menu selector configuration registers
// Holds the controller and note numbers written over the configuration port.
// ----------------------------------------------------------------------------
module mms_cfg_regs
    import mms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [6:0] cfg_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the register index; unknown indexes leave everything unchanged.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_NEXT_CTRL:   cfg_next.next_ctrl   = cfg_data;
                CFG_PREV_CTRL:   cfg_next.prev_ctrl   = cfg_data;
                CFG_SELECT_CTRL: cfg_next.select_ctrl = cfg_data;
                CFG_NOTE_FIRST:  cfg_next.note_first  = cfg_data;
                CFG_NOTE_SECOND: cfg_next.note_second = cfg_data;
                CFG_NOTE_THIRD:  cfg_next.note_third  = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.next_ctrl   <= RST_NEXT_CTRL;
            cfg_reg.prev_ctrl   <= RST_PREV_CTRL;
            cfg_reg.select_ctrl <= RST_SELECT_CTRL;
            cfg_reg.note_first  <= RST_NOTE_FIRST;
            cfg_reg.note_second <= RST_NOTE_SECOND;
            cfg_reg.note_third  <= RST_NOTE_THIRD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/core/mms_step_logic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI menu selector step logic
// Works out the next parser and menu state and the result for one beat.
// ----------------------------------------------------------------------------
module mms_step_logic
    import mms_pkg::*;
#(
    parameter int ENTRY_COUNT = ENTRY_COUNT_DEFAULT
)
(
    input  action_t    action,
    input  logic [7:0] midi_byte,
    input  cfg_t       cfg,
    input  state_t     state,
    output state_t     state_next,
    output result_t    result
);

    // Wrapping step forward over the menu entries.
    function automatic logic [1:0] step_fwd(input logic [1:0] sel);
        if (({1'b0, sel} + 3'd1) >= 3'(ENTRY_COUNT))
            return 2'd0;
        else
            return sel + 2'd1;
    endfunction

    // Wrapping step back; an out-of-range index goes to the last entry.
    function automatic logic [1:0] step_back(input logic [1:0] sel);
        if ((sel == 2'd0) || ({1'b0, sel} >= 3'(ENTRY_COUNT)))
            return 2'(ENTRY_COUNT - 1);
        else
            return sel - 2'd1;
    endfunction

    logic [7:0] msg_first;
    logic [7:0] msg_second;
    logic [3:0] msg_kind;
    logic       msg_live;
    logic       hit_next;
    logic       hit_prev;
    logic       hit_select;
    logic       note_hit;
    logic [1:0] note_entry;
    logic [6:0] notes [NOTE_COUNT];
    logic       act_en;
    logic       redraw;
    logic       complete;

    assign notes[0] = cfg.note_first;
    assign notes[1] = cfg.note_second;
    assign notes[2] = cfg.note_third;

    // The data bytes of the message being finished by this beat.
    assign msg_first  = (state.byte_index == IDX_STATUS) ? midi_byte : state.first_data;
    assign msg_second = (state.byte_index == IDX_STATUS) ? 8'd0 : midi_byte;
    assign msg_kind   = state.running_status[7:4];
    assign msg_live   = (msg_second != 8'd0);

    assign hit_next   = (msg_first == {1'b0, cfg.next_ctrl});
    assign hit_prev   = (msg_first == {1'b0, cfg.prev_ctrl});
    assign hit_select = (msg_first == {1'b0, cfg.select_ctrl});

    // Note match: the lowest matching entry wins.
    always_comb
    begin
        note_hit   = 1'b0;
        note_entry = 2'd0;
        for (int k = NOTE_COUNT - 1; k >= 0; k--)
        begin
            if ((k < ENTRY_COUNT) && (msg_first == {1'b0, notes[k]}))
            begin
                note_hit   = 1'b1;
                note_entry = 2'(k);
            end
        end
    end

    // Parser and menu update.
    always_comb
    begin
        state_next = state;
        redraw     = 1'b0;
        complete   = 1'b0;
        act_en     = 1'b0;
        case (action)
            ACT_FWD:
            begin
                state_next.selected_entry = step_fwd(state.selected_entry);
                redraw = 1'b1;
            end
            ACT_BACK:
            begin
                state_next.selected_entry = step_back(state.selected_entry);
                redraw = 1'b1;
            end
            ACT_CONFIRM:
            begin
                state_next.start_flag = 1'b1;
            end
            ACT_MIDI:
            begin
                if (midi_byte[7])
                begin
                    state_next.running_status = midi_byte;
                    state_next.byte_index     = IDX_STATUS;
                    if ((midi_byte[7:4] == KIND_PROGRAM) || (midi_byte[7:4] == KIND_PRESSURE))
                        state_next.message_length = LEN_TWO;
                    else
                        state_next.message_length = LEN_THREE;
                end
                else if (state.byte_index == IDX_STATUS)
                begin
                    state_next.first_data = midi_byte;
                    if (state.message_length == LEN_TWO)
                    begin
                        act_en   = 1'b1;
                        complete = 1'b1;
                    end
                    else
                    begin
                        state_next.byte_index = IDX_DATA;
                    end
                end
                else if (state.byte_index == IDX_DATA)
                begin
                    act_en                = 1'b1;
                    complete              = 1'b1;
                    state_next.byte_index = IDX_STATUS;
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase

        // Act on a finished message.
        if (act_en && msg_live)
        begin
            if (msg_kind == KIND_CTRL)
            begin
                if (hit_next)
                begin
                    state_next.selected_entry = step_fwd(state.selected_entry);
                    redraw = 1'b1;
                end
                else if (hit_prev)
                begin
                    state_next.selected_entry = step_back(state.selected_entry);
                    redraw = 1'b1;
                end
                else if (hit_select)
                begin
                    state_next.start_flag = 1'b1;
                end
            end
            else if ((msg_kind == KIND_NOTE_ON) && note_hit)
            begin
                state_next.selected_entry = note_entry;
                state_next.start_flag     = 1'b1;
            end
        end
    end

    assign result.selection        = state_next.selected_entry;
    assign result.start_requested  = state_next.start_flag;
    assign result.redraw           = redraw;
    assign result.message_complete = complete;

endmodule

FILE: rtl/core/midi_menu_selector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI menu selector core
// Parses MIDI bytes and local events into a menu selection and start request.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid/in_ready) carry an action code and a MIDI byte.
//   Action 0 feeds the byte to the MIDI parser; 1, 2 and 3 are local step
//   forward, step back and confirm events.
//   Every input beat gives exactly one output beat (out_valid/out_ready) with
//   the selection, the sticky start flag, a redraw flag and a message flag.
//   The configuration channel (cfg_valid/cfg_ready) writes the controller and
//   note numbers; it is always ready and should be used only while idle.
//   A beat lands in the input register, and its result then lands in the
//   output register, where the state is updated. Throughput is one beat
//   per cycle while out_ready is high; both register stages advance together.
//   When the receiver stalls, the result holds in the output register and one
//   more beat is held in the input register, after which in_ready drops.
//   Reset clears the parser and menu state, empties both stages and loads the
//   default controller and note numbers.
// ----------------------------------------------------------------------------
module midi_menu_selector_core
    import mms_pkg::*;
#(
    parameter int ENTRY_COUNT = ENTRY_COUNT_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] action,
    input  logic [7:0] midi_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] selection,
    output logic       start_requested,
    output logic       redraw,
    output logic       message_complete,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [6:0] cfg_data
);

    cfg_t       cfg;
    state_t     state_reg;
    state_t     state_next;
    result_t    result;
    result_t    result_reg;
    logic       s1_valid_reg;
    action_t    s1_action_reg;
    logic [7:0] s1_byte_reg;
    logic       out_valid_reg;
    logic       s1_advance;

    mms_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mms_step_logic #(
        .ENTRY_COUNT (ENTRY_COUNT)
    ) u_step_logic (
        .action     (s1_action_reg),
        .midi_byte  (s1_byte_reg),
        .cfg        (cfg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result)
    );

    // Handshake: the input stage moves on whenever the output register frees up.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || !out_valid_reg || out_ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_action_reg <= action_t'(action);
            s1_byte_reg   <= midi_byte;
        end
    end

    // Parser and menu state, updated as a beat enters the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.running_status <= 8'd0;
            state_reg.byte_index     <= IDX_NONE;
            state_reg.message_length <= LEN_THREE;
            state_reg.first_data     <= 8'd0;
            state_reg.selected_entry <= 2'd0;
            state_reg.start_flag     <= 1'b0;
        end
        else if (s1_advance)
        begin
            state_reg <= state_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid        = out_valid_reg;
    assign selection        = result_reg.selection;
    assign start_requested  = result_reg.start_requested;
    assign redraw           = result_reg.redraw;
    assign message_complete = result_reg.message_complete;

endmodule

FILE: rtl/core/mms_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI menu selector checker
// Port-level assertions for the MIDI menu selector core, bound to the top.
// ----------------------------------------------------------------------------
module mms_checker
    import mms_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] selection,
    input logic       start_requested,
    input logic       redraw,
    input logic       message_complete
);

    // A stalled output beat holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(selection)
            && $stable(start_requested) && $stable(redraw) && $stable(message_complete))
        else $error("stalled output beat changed");

    // The selection never shows the unused code.
    a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (selection != 2'd3))
        else $error("selection out of range");

    // Once a start was requested, it stays requested.
    a_start_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && start_requested |=> !out_valid || start_requested)
        else $error("start request dropped");

    // Input back-pressure only comes from a stalled output.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output stall");

endmodule

bind midi_menu_selector_core mms_checker u_mms_checker (.*);
